@@ rtl/sorted_list_merge_defines.svh @@
// Assertion macros shared by the sorted list merge RTL.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef SORTED_LIST_MERGE_DEFINES_SVH
`define SORTED_LIST_MERGE_DEFINES_SVH
`ifndef SYNTHESIS
`define SLM_ASSERT(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("assertion failed");
`define SLM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SLM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SLM_ASSERT(label, cond)
`define SLM_ASSERT_IMPL(label, ante, cons)
`define SLM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ rtl/slm_pkg.sv @@
// Package for the sorted list merge: request codes, state type and status struct.
// No dependencies.
package slm_pkg;

    localparam logic [1:0] REQ_APPEND_A = 2'd0;
    localparam logic [1:0] REQ_APPEND_B = 2'd1;
    localparam logic [1:0] REQ_MERGE    = 2'd2;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 6;

    typedef enum logic {
        S_IDLE,
        S_MERGE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_core_stat;

endpackage

@@ rtl/slm_list_ram.sv @@
// One list store: a synchronous memory with one write port and one registered read port.
// Depends on slm_pkg.
module slm_list_ram #(
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [AW-1:0]                i_waddr,
    input  logic [slm_pkg::VALUE_W-1:0]  i_wdata,
    input  logic [AW-1:0]                i_raddr,
    output logic [slm_pkg::VALUE_W-1:0]  o_rdata
);
    import slm_pkg::*;

    logic [VALUE_W-1:0] r_mem [DEPTH];
    logic [VALUE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/slm_merge_core.sv @@
// Merge sequencer: walks both list stores, picks the smaller head each cycle
// and registers one result beat per cycle. Depends on slm_pkg and the defines header.
`include "sorted_list_merge_defines.svh"
module slm_merge_core #(
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_go,
    input  logic [CW-1:0]                i_count_a,
    input  logic [CW-1:0]                i_count_b,
    input  logic                         i_overflow,
    input  logic [slm_pkg::VALUE_W-1:0]  i_rdata_a,
    input  logic [slm_pkg::VALUE_W-1:0]  i_rdata_b,
    output logic [AW-1:0]                o_raddr_a,
    output logic [AW-1:0]                o_raddr_b,
    output slm_pkg::t_core_stat          o_stat,
    output logic                         o_strobe,
    output logic [slm_pkg::VALUE_W-1:0]  o_merged_value,
    output logic                         o_from_b,
    output logic [slm_pkg::POS_W-1:0]    o_position,
    output logic                         o_overflowed,
    output logic                         o_last
);
    import slm_pkg::*;

    localparam int PW = CW + 1;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_ia, n_ia;
    logic [CW-1:0]      r_ib, n_ib;
    logic [PW-1:0]      r_k, n_k;
    logic [PW-1:0]      r_total, n_total;
    logic [PW-1:0]      w_sum;
    logic               w_take_a;
    logic               w_last;

    logic               r_strobe;
    logic [VALUE_W-1:0] r_value;
    logic               r_from_b;
    logic [POS_W-1:0]   r_pos;
    logic               r_ovf;
    logic               r_last;

    assign w_sum = PW'(i_count_a) + PW'(i_count_b);

    // The held read data is the current head of each list; a list that ran
    // out forces the pick to the other one, and ties go to list B.
    assign w_take_a = (r_ia < i_count_a) &&
                      ((r_ib >= i_count_b) || ($signed(i_rdata_a) < $signed(i_rdata_b)));
    assign w_last   = (PW'(r_k + PW'(1)) == r_total);

    always_comb begin
        n_state = r_state;
        n_ia    = '0;
        n_ib    = '0;
        n_k     = r_k;
        n_total = r_total;
        case (r_state)
            S_IDLE: begin
                n_k = '0;
                if (i_go && (w_sum != '0)) begin
                    n_state = S_MERGE;
                    n_total = w_sum;
                end
            end
            S_MERGE: begin
                n_ia = r_ia + CW'(w_take_a);
                n_ib = r_ib + CW'(!w_take_a);
                n_k  = PW'(r_k + PW'(1));
                if (w_last) begin
                    n_state = S_IDLE;
                    n_ia    = '0;
                    n_ib    = '0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ia     <= '0;
            r_ib     <= '0;
            r_k      <= '0;
            r_total  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ia     <= n_ia;
            r_ib     <= n_ib;
            r_k      <= n_k;
            r_total  <= n_total;
            r_strobe <= (r_state == S_MERGE);
        end
    end

    always_ff @(posedge i_clk) begin
        r_value  <= w_take_a ? i_rdata_a : i_rdata_b;
        r_from_b <= !w_take_a;
        r_pos    <= POS_W'(r_k);
        r_ovf    <= i_overflow;
        r_last   <= w_last;
    end

    // Next read addresses follow the advanced indices so the new head is
    // ready in the next cycle.
    assign o_raddr_a = n_ia[AW-1:0];
    assign o_raddr_b = n_ib[AW-1:0];

    assign o_stat.busy = (r_state == S_MERGE);
    assign o_stat.done = (r_state == S_MERGE) && w_last;

    assign o_strobe       = r_strobe;
    assign o_merged_value = r_value;
    assign o_from_b       = r_from_b;
    assign o_position     = r_pos;
    assign o_overflowed   = r_ovf;
    assign o_last         = r_last;

    `SLM_ASSERT(idx_in_range, (r_state != S_MERGE) || ((r_ia <= i_count_a) && (r_ib <= i_count_b)))
    `SLM_ASSERT_IMPL(take_a_has_data, (r_state == S_MERGE) && w_take_a, r_ia < i_count_a)
    `SLM_ASSERT_IMPL(take_b_has_data, (r_state == S_MERGE) && !w_take_a, r_ib < i_count_b)
    `SLM_ASSERT_NEXT(beat_follows_merge, r_state == S_MERGE, r_strobe)
    `SLM_ASSERT_NEXT(last_ends_merge, (r_state == S_MERGE) && w_last, (r_state == S_IDLE) && r_last)

endmodule

@@ rtl/sorted_list_merge.sv @@
// Top level of the two-way merge of sorted lists: list counts, overflow flag,
// append writes, two list stores and the merge sequencer. Depends on slm_pkg,
// slm_list_ram, slm_merge_core and the defines header.
//
//  Channel  | Direction | Handshake                | Payload
//  ---------+-----------+--------------------------+-----------------------------------
//  Request  | in        | start high, busy low     | i_req_type, i_value
//  Result   | out       | o_strobe, one cycle only | o_merged_value, o_from_b,
//           |           |                          | o_position, o_overflowed, o_last
//
// Appends can arrive back to back; busy stays low.
// A merge with N stored elements raises busy while it reads one element
// per cycle from each list store; result beats follow in the next cycle
// through the output register. A merge of two empty lists emits nothing.
// Reset is synchronous and clears counts, overflow flag and sequencer; the
// list stores are not cleared. Results cannot be stalled by the receiver.
`include "sorted_list_merge_defines.svh"
module sorted_list_merge #(
    parameter int LIST_DEPTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_req_type,
    input  logic signed [slm_pkg::VALUE_W-1:0] i_value,
    output logic                         o_strobe,
    output logic signed [slm_pkg::VALUE_W-1:0] o_merged_value,
    output logic                         o_from_b,
    output logic [slm_pkg::POS_W-1:0]    o_position,
    output logic                         o_overflowed,
    output logic                         o_last
);
    import slm_pkg::*;

    localparam int AW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);

    logic [CW-1:0]      r_count_a, n_count_a;
    logic [CW-1:0]      r_count_b, n_count_b;
    logic               r_ovf, n_ovf;

    logic               w_accept;
    logic               w_we_a;
    logic               w_we_b;
    logic               w_go;
    logic [AW-1:0]      w_raddr_a;
    logic [AW-1:0]      w_raddr_b;
    logic [VALUE_W-1:0] w_rdata_a;
    logic [VALUE_W-1:0] w_rdata_b;
    logic [VALUE_W-1:0] w_merged;
    t_core_stat         w_stat;

    assign busy     = w_stat.busy;
    assign w_accept = start && !w_stat.busy;

    // Append and merge decode. A full list drops the element and sets the
    // sticky overflow flag; the unused request code does nothing.
    always_comb begin
        n_count_a = r_count_a;
        n_count_b = r_count_b;
        n_ovf     = r_ovf;
        w_we_a    = 1'b0;
        w_we_b    = 1'b0;
        w_go      = 1'b0;
        if (w_accept) begin
            case (i_req_type)
                REQ_APPEND_A: begin
                    if (r_count_a < CW'(LIST_DEPTH)) begin
                        w_we_a    = 1'b1;
                        n_count_a = r_count_a + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                REQ_APPEND_B: begin
                    if (r_count_b < CW'(LIST_DEPTH)) begin
                        w_we_b    = 1'b1;
                        n_count_b = r_count_b + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                REQ_MERGE: begin
                    w_go = 1'b1;
                end
                default: begin
                    w_go = 1'b0;
                end
            endcase
        end
        // Both lists are consumed once the final element has been picked.
        // A merge of two empty lists leaves the counts at zero as they are.
        if (w_stat.done) begin
            n_count_a = '0;
            n_count_b = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_a <= '0;
            r_count_b <= '0;
            r_ovf     <= 1'b0;
        end else begin
            r_count_a <= n_count_a;
            r_count_b <= n_count_b;
            r_ovf     <= n_ovf;
        end
    end

    slm_list_ram #(
        .DEPTH (LIST_DEPTH)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (w_we_a),
        .i_waddr (r_count_a[AW-1:0]),
        .i_wdata (i_value),
        .i_raddr (w_raddr_a),
        .o_rdata (w_rdata_a)
    );

    slm_list_ram #(
        .DEPTH (LIST_DEPTH)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (w_we_b),
        .i_waddr (r_count_b[AW-1:0]),
        .i_wdata (i_value),
        .i_raddr (w_raddr_b),
        .o_rdata (w_rdata_b)
    );

    slm_merge_core #(
        .DEPTH (LIST_DEPTH)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_go           (w_go),
        .i_count_a      (r_count_a),
        .i_count_b      (r_count_b),
        .i_overflow     (r_ovf),
        .i_rdata_a      (w_rdata_a),
        .i_rdata_b      (w_rdata_b),
        .o_raddr_a      (w_raddr_a),
        .o_raddr_b      (w_raddr_b),
        .o_stat         (w_stat),
        .o_strobe       (o_strobe),
        .o_merged_value (w_merged),
        .o_from_b       (o_from_b),
        .o_position     (o_position),
        .o_overflowed   (o_overflowed),
        .o_last         (o_last)
    );

    assign o_merged_value = $signed(w_merged);

    `SLM_ASSERT(count_in_range, (r_count_a <= CW'(LIST_DEPTH)) && (r_count_b <= CW'(LIST_DEPTH)))
    `SLM_ASSERT_NEXT(nonempty_merge_busy, w_go && ((r_count_a != '0) || (r_count_b != '0)), busy)
    `SLM_ASSERT_NEXT(overflow_sticky, r_ovf, r_ovf)

endmodule
